[rtl/core/i2cram_pkg.sv]
// ----------------------------------------------------------------------------
// i2cram_pkg
// shared types and constants for the i2c register access master
// ----------------------------------------------------------------------------
package i2cram_pkg;

  localparam int unsigned DEV_ADDR_W = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RST = 7'd104;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // register index, taken from paddr above the byte offset
  localparam logic REG_DEV_ADDR = 1'b0;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   reg_address;
    logic [BYTE_W-1:0]   write_data;
    logic                sda_in;
  } in_word_t;

  typedef struct packed {
    logic              scl;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              ack_ok;
  } out_word_t;

endpackage

[rtl/core/i2cram_cfg.sv]
// ----------------------------------------------------------------------------
// i2cram_cfg
// apb register file holding the target device address
// ----------------------------------------------------------------------------
module i2cram_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cram_pkg::PADDR_W-1:0]      paddr,
  input  logic [i2cram_pkg::PDATA_W-1:0]      pwdata,
  output logic [i2cram_pkg::PDATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [i2cram_pkg::DEV_ADDR_W-1:0]   dev_addr
);

  logic [i2cram_pkg::DEV_ADDR_W-1:0] dev_addr_r;
  logic [i2cram_pkg::DEV_ADDR_W-1:0] dev_addr_nxt;
  logic                              wr_en;
  logic                              sel_dev;

  assign pready  = 1'b1;
  assign sel_dev = (paddr[i2cram_pkg::PADDR_W-1] == i2cram_pkg::REG_DEV_ADDR);
  assign wr_en   = psel && penable && pwrite && sel_dev;

  always_comb begin
    dev_addr_nxt = dev_addr_r;
    if (wr_en) begin
      dev_addr_nxt = pwdata[i2cram_pkg::DEV_ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= i2cram_pkg::DEV_ADDR_RST;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_dev) begin
      prdata[i2cram_pkg::DEV_ADDR_W-1:0] = dev_addr_r;
    end
  end

  assign dev_addr = dev_addr_r;

endmodule

[rtl/core/i2cram_seq.sv]
// ----------------------------------------------------------------------------
// i2cram_seq
// bus sequencer: one step of the transaction per accepted tick word
// ----------------------------------------------------------------------------
module i2cram_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  i2cram_pkg::in_word_t              in_word,
  input  logic [i2cram_pkg::DEV_ADDR_W-1:0] dev_addr,
  output i2cram_pkg::out_word_t             res
);

  localparam int unsigned STEP_W = 5;

  localparam logic [STEP_W-1:0] ST_IDLE        = 5'd0;
  localparam logic [STEP_W-1:0] ST_START_SDA   = 5'd1;
  localparam logic [STEP_W-1:0] ST_START_SCL   = 5'd2;
  localparam logic [STEP_W-1:0] ST_BIT_SET     = 5'd3;
  localparam logic [STEP_W-1:0] ST_BIT_HIGH    = 5'd4;
  localparam logic [STEP_W-1:0] ST_BIT_LOW     = 5'd5;
  localparam logic [STEP_W-1:0] ST_ACK_REL     = 5'd6;
  localparam logic [STEP_W-1:0] ST_ACK_HIGH    = 5'd7;
  localparam logic [STEP_W-1:0] ST_ACK_LOW     = 5'd8;
  localparam logic [STEP_W-1:0] ST_RS_SDA_HI   = 5'd9;
  localparam logic [STEP_W-1:0] ST_RS_SCL_HI   = 5'd10;
  localparam logic [STEP_W-1:0] ST_RS_SDA_LO   = 5'd11;
  localparam logic [STEP_W-1:0] ST_RS_SCL_LO   = 5'd12;
  localparam logic [STEP_W-1:0] ST_RD_REL      = 5'd13;
  localparam logic [STEP_W-1:0] ST_RD_HIGH     = 5'd14;
  localparam logic [STEP_W-1:0] ST_RD_LOW      = 5'd15;
  localparam logic [STEP_W-1:0] ST_NACK_HIGH   = 5'd16;
  localparam logic [STEP_W-1:0] ST_NACK_LOW    = 5'd17;
  localparam logic [STEP_W-1:0] ST_STOP_SDA_LO = 5'd18;
  localparam logic [STEP_W-1:0] ST_STOP_SCL_HI = 5'd19;
  localparam logic [STEP_W-1:0] ST_STOP_SDA_HI = 5'd20;

  // which sent byte is on the bus
  localparam logic [1:0] BYTE_ADDR_W = 2'd0;
  localparam logic [1:0] BYTE_REG    = 2'd1;
  localparam logic [1:0] BYTE_DATA   = 2'd2;
  localparam logic [1:0] BYTE_ADDR_R = 2'd3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam int unsigned BW = i2cram_pkg::BYTE_W;

  logic [STEP_W-1:0] step_r,      step_nxt;
  logic [3:0]        bit_idx_r,   bit_idx_nxt;
  logic [BW-1:0]     shift_r,     shift_nxt;
  logic [BW-1:0]     rx_byte_r,   rx_byte_nxt;
  logic              all_acked_r, all_acked_nxt;
  logic              is_read_r,   is_read_nxt;
  logic [BW-1:0]     hold_reg_r,  hold_reg_nxt;
  logic [BW-1:0]     hold_data_r, hold_data_nxt;
  logic              scl_r,       scl_nxt;
  logic              sda_r,       sda_nxt;
  logic [1:0]        byte_cnt_r,  byte_cnt_nxt;
  logic              busy;
  logic              done;
  logic [BW-1:0]     addr_w_byte;
  logic [BW-1:0]     addr_r_byte;
  logic [3:0]        bit_idx_inc;

  assign addr_w_byte = {dev_addr, 1'b0};
  assign addr_r_byte = {dev_addr, 1'b1};
  assign bit_idx_inc = bit_idx_r + 4'd1;

  always_comb begin
    step_nxt      = step_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    rx_byte_nxt   = rx_byte_r;
    all_acked_nxt = all_acked_r;
    is_read_nxt   = is_read_r;
    hold_reg_nxt  = hold_reg_r;
    hold_data_nxt = hold_data_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    byte_cnt_nxt  = byte_cnt_r;
    busy          = 1'b1;
    done          = 1'b0;

    unique case (step_r)
      ST_IDLE: begin
        if (in_word.action == i2cram_pkg::ACT_WRITE ||
            in_word.action == i2cram_pkg::ACT_READ) begin
          is_read_nxt   = (in_word.action == i2cram_pkg::ACT_READ);
          hold_reg_nxt  = in_word.reg_address;
          hold_data_nxt = in_word.write_data;
          all_acked_nxt = 1'b1;
          sda_nxt       = 1'b0;
          step_nxt      = ST_START_SDA;
        end else begin
          busy = 1'b0;
        end
      end
      ST_START_SDA: begin
        scl_nxt  = 1'b0;
        step_nxt = ST_START_SCL;
      end
      ST_START_SCL: begin
        // first address bit goes out right away
        shift_nxt    = addr_w_byte;
        byte_cnt_nxt = BYTE_ADDR_W;
        bit_idx_nxt  = '0;
        sda_nxt      = addr_w_byte[BW-1];
        step_nxt     = ST_BIT_HIGH;
      end
      ST_BIT_SET: begin
        sda_nxt  = shift_r[BW-1];
        step_nxt = ST_BIT_HIGH;
      end
      ST_BIT_HIGH: begin
        scl_nxt  = 1'b1;
        step_nxt = ST_BIT_LOW;
      end
      ST_BIT_LOW: begin
        scl_nxt     = 1'b0;
        shift_nxt   = {shift_r[BW-2:0], 1'b0};
        bit_idx_nxt = bit_idx_inc;
        step_nxt    = (bit_idx_inc >= BITS_PER_BYTE) ? ST_ACK_REL : ST_BIT_SET;
      end
      ST_ACK_REL: begin
        sda_nxt  = 1'b1;
        step_nxt = ST_ACK_HIGH;
      end
      ST_ACK_HIGH: begin
        scl_nxt = 1'b1;
        if (in_word.sda_in) begin
          all_acked_nxt = 1'b0;
        end
        step_nxt = ST_ACK_LOW;
      end
      ST_ACK_LOW: begin
        scl_nxt = 1'b0;
        priority if (byte_cnt_r == BYTE_ADDR_W) begin
          shift_nxt    = hold_reg_r;
          byte_cnt_nxt = BYTE_REG;
          bit_idx_nxt  = '0;
          step_nxt     = ST_BIT_SET;
        end else if (byte_cnt_r == BYTE_REG && !is_read_r) begin
          shift_nxt    = hold_data_r;
          byte_cnt_nxt = BYTE_DATA;
          bit_idx_nxt  = '0;
          step_nxt     = ST_BIT_SET;
        end else if (byte_cnt_r == BYTE_REG) begin
          step_nxt = ST_RS_SDA_HI;
        end else if (byte_cnt_r == BYTE_ADDR_R) begin
          bit_idx_nxt = '0;
          shift_nxt   = '0;
          step_nxt    = ST_RD_REL;
        end else begin
          step_nxt = ST_STOP_SDA_LO;
        end
      end
      ST_RS_SDA_HI: begin
        sda_nxt  = 1'b1;
        step_nxt = ST_RS_SCL_HI;
      end
      ST_RS_SCL_HI: begin
        scl_nxt  = 1'b1;
        step_nxt = ST_RS_SDA_LO;
      end
      ST_RS_SDA_LO: begin
        sda_nxt  = 1'b0;
        step_nxt = ST_RS_SCL_LO;
      end
      ST_RS_SCL_LO: begin
        scl_nxt      = 1'b0;
        shift_nxt    = addr_r_byte;
        byte_cnt_nxt = BYTE_ADDR_R;
        bit_idx_nxt  = '0;
        step_nxt     = ST_BIT_SET;
      end
      ST_RD_REL: begin
        sda_nxt  = 1'b1;
        step_nxt = ST_RD_HIGH;
      end
      ST_RD_HIGH: begin
        scl_nxt   = 1'b1;
        shift_nxt = {shift_r[BW-2:0], in_word.sda_in};
        step_nxt  = ST_RD_LOW;
      end
      ST_RD_LOW: begin
        scl_nxt     = 1'b0;
        bit_idx_nxt = bit_idx_inc;
        step_nxt    = (bit_idx_inc >= BITS_PER_BYTE) ? ST_NACK_HIGH : ST_RD_HIGH;
      end
      ST_NACK_HIGH: begin
        sda_nxt  = 1'b1;
        scl_nxt  = 1'b1;
        step_nxt = ST_NACK_LOW;
      end
      ST_NACK_LOW: begin
        scl_nxt  = 1'b0;
        step_nxt = ST_STOP_SDA_LO;
      end
      ST_STOP_SDA_LO: begin
        sda_nxt  = 1'b0;
        step_nxt = ST_STOP_SCL_HI;
      end
      ST_STOP_SCL_HI: begin
        scl_nxt  = 1'b1;
        step_nxt = ST_STOP_SDA_HI;
      end
      ST_STOP_SDA_HI: begin
        sda_nxt = 1'b1;
        done    = 1'b1;
        if (is_read_r) begin
          rx_byte_nxt = shift_r;
        end
        step_nxt = ST_IDLE;
      end
      default: begin
        // unused step codes fall back to idle with the bus released
        scl_nxt  = 1'b1;
        sda_nxt  = 1'b1;
        busy     = 1'b0;
        step_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      rx_byte_r   <= '0;
      all_acked_r <= 1'b1;
      is_read_r   <= 1'b0;
      hold_reg_r  <= '0;
      hold_data_r <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      byte_cnt_r  <= BYTE_ADDR_W;
    end else if (step_en) begin
      step_r      <= step_nxt;
      bit_idx_r   <= bit_idx_nxt;
      shift_r     <= shift_nxt;
      rx_byte_r   <= rx_byte_nxt;
      all_acked_r <= all_acked_nxt;
      is_read_r   <= is_read_nxt;
      hold_reg_r  <= hold_reg_nxt;
      hold_data_r <= hold_data_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
    end
  end

  always_comb begin
    res.scl       = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = busy;
    res.done_res  = done;
    res.read_data = rx_byte_nxt;
    res.ack_ok    = all_acked_nxt;
  end

endmodule

[rtl/core/i2cram_out.sv]
// ----------------------------------------------------------------------------
// i2cram_out
// result register with valid/stall handshake toward the consumer
// ----------------------------------------------------------------------------
module i2cram_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cram_pkg::out_word_t res,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cram_pkg::out_word_t out_data,
  output logic                  step_en
);

  logic                  valid_r;
  logic                  valid_nxt;
  i2cram_pkg::out_word_t data_r;

  // a new word may enter when the held one is gone or leaves this cycle
  assign in_stall  = valid_r && out_stall;
  assign step_en   = in_valid && !in_stall;
  assign valid_nxt = step_en || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[rtl/core/i2c_register_access_master.sv]
// ----------------------------------------------------------------------------
// i2c_register_access_master
// i2c master for a single device-register write or read, one tick per word
// ----------------------------------------------------------------------------
// output: a tick's result word is registered and valid the cycle after acceptance
// throughput: one tick word per cycle unless a held result is stalled, set by the
// single-step sequencer and the result register, which stalls new ticks meanwhile
// reset (rst_n low, synchronous): sequencer idle, bus released, device address 104,
// result register empty
module i2c_register_access_master (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  i2cram_pkg::in_word_t              in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output i2cram_pkg::out_word_t             out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cram_pkg::PADDR_W-1:0]    paddr,
  input  logic [i2cram_pkg::PDATA_W-1:0]    pwdata,
  output logic [i2cram_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [i2cram_pkg::DEV_ADDR_W-1:0] dev_addr;
  logic                              step_en;
  i2cram_pkg::out_word_t             res;

  i2cram_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .dev_addr (dev_addr)
  );

  i2cram_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .in_word  (in_data),
    .dev_addr (dev_addr),
    .res      (res)
  );

  i2cram_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .step_en   (step_en)
  );

endmodule
